// ----- rtl/mdcd_pkg.sv -----
`timescale 1ns / 1ps

package mdcd_pkg;

	// Field widths
	localparam int unsigned SAMPLE_W   = 16;
	localparam int unsigned DIFF_W     = SAMPLE_W + 1;
	localparam int unsigned STAT_W     = 40;
	localparam int unsigned COUNT_W    = 32;
	localparam int unsigned USED_W     = 3;
	localparam int unsigned DRIFT_REGS = 4;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 40;

	// Increment datapath: 2d - m, then m * (2d - m)
	localparam int unsigned TDM_W  = DIFF_W + 2;
	localparam int unsigned PROD_W = TDM_W + SAMPLE_W;
	localparam int unsigned INC_W  = PROD_W - 1;
	localparam int unsigned SUM_W  = STAT_W + 2;

	localparam int unsigned OUT_DATA_W = STAT_W + COUNT_W;

	typedef logic [STAT_W-1:0] stat_t;

	// Register indexes on the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASELINE,
		REG_THRESHOLD,
		REG_DRIFTS_USED,
		REG_DRIFT_A,
		REG_DRIFT_B,
		REG_DRIFT_C,
		REG_DRIFT_D
	} reg_idx_t;

	// Per-lane pipeline strobes
	typedef struct packed {
		logic load_s2;
		logic update;
	} lane_ctl_t;

endpackage

// ----- rtl/multi_drift_cusum_detector_core.sv -----
`timescale 1ns / 1ps

// Multi-drift Page CUSUM change detector.
// Input stream s_axis carries one signed Q8.8 sample per word in tdata.
// Output stream m_axis carries one result word per sample: tdata holds the
// largest statistic (Q24.16) and the saturating sample count, tuser the alarm.
// Configuration is written through cfg_we / cfg_index / cfg_data; the user must
// do so only while idle, as the block itself does not enforce it.
// Pipeline: input register, increment stage (one multiplier per drift lane),
// statistic update stage, then max/threshold compare into the output register.
// Throughput is one word per cycle while the receiver is not stalling m_axis.
// Each stage holds its word while the one after it is full, so input words
// keep being taken until all stages are full behind a stalled receiver.
// After the word that raises the alarm, no further words are produced;
// input words are still taken and discarded until reset.
// Reset (arst_n low) clears all statistics, the count, the alarm and every
// configuration register to its default value, and empties the pipeline.
module multi_drift_cusum_detector_core #(
	parameter int unsigned DRIFT_POINTS = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Configuration write port
	input  logic                                 cfg_we,
	input  logic [mdcd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mdcd_pkg::CFG_DATA_W-1:0]      cfg_data,
	// Sample input
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [mdcd_pkg::SAMPLE_W-1:0]        s_axis_tdata,   // [15:0] sample
	// Result output
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [mdcd_pkg::OUT_DATA_W-1:0]      m_axis_tdata,   // [39:0] max_statistic,
	                                                             // [71:40] sample_index
	output logic                                 m_axis_tuser    // [0] alarm
);
	import mdcd_pkg::*;

	// Configuration registers
	logic signed [SAMPLE_W-1:0] baseline_q;
	stat_t                      threshold_q;
	logic [USED_W-1:0]          drifts_used_q;
	logic signed [SAMPLE_W-1:0] drift_q [DRIFT_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			baseline_q    <= '0;
			threshold_q   <= '1;
			drifts_used_q <= USED_W'(4);
			drift_q[0]    <= SAMPLE_W'(256);
			drift_q[1]    <= SAMPLE_W'(512);
			drift_q[2]    <= -SAMPLE_W'(256);
			drift_q[3]    <= -SAMPLE_W'(512);
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_BASELINE:    baseline_q    <= cfg_data[SAMPLE_W-1:0];
				REG_THRESHOLD:   threshold_q   <= cfg_data[STAT_W-1:0];
				REG_DRIFTS_USED: drifts_used_q <= cfg_data[USED_W-1:0];
				REG_DRIFT_A:     drift_q[0]    <= cfg_data[SAMPLE_W-1:0];
				REG_DRIFT_B:     drift_q[1]    <= cfg_data[SAMPLE_W-1:0];
				REG_DRIFT_C:     drift_q[2]    <= cfg_data[SAMPLE_W-1:0];
				REG_DRIFT_D:     drift_q[3]    <= cfg_data[SAMPLE_W-1:0];
				default: ;
			endcase
		end
	end

	// Drift count clamped to [1, DRIFT_POINTS]
	logic [USED_W-1:0] used;

	always_comb begin
		if (drifts_used_q == '0) begin
			used = USED_W'(1);
		end else if (drifts_used_q > USED_W'(DRIFT_POINTS)) begin
			used = USED_W'(DRIFT_POINTS);
		end else begin
			used = drifts_used_q;
		end
	end

	// Pipeline occupancy and per-stage ready
	logic v_s1, v_s2, v_s3;
	logic ready_s1, ready_s2, ready_s3, ready_out;

	assign ready_out     = !m_axis_tvalid || m_axis_tready;
	assign ready_s3      = !v_s3 || ready_out;
	assign ready_s2      = !v_s2 || ready_s3;
	assign ready_s1      = !v_s1 || ready_s2;
	assign s_axis_tready = ready_s1;

	logic load_s2, move_s3;
	assign load_s2 = v_s1 && ready_s2;
	assign move_s3 = v_s2 && ready_s3;

	// Stage 1: input register
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic signed [DIFF_W-1:0]   diff_s1;

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && ready_s1) begin
			sample_s1 <= s_axis_tdata;
		end
	end

	assign diff_s1 = {sample_s1[SAMPLE_W-1], sample_s1} - {baseline_q[SAMPLE_W-1], baseline_q};

	// Drift lanes: increment in stage 2, statistic update on the move to stage 3
	stat_t stats [DRIFT_POINTS];

	for (genvar i = 0; i < DRIFT_POINTS; i++) begin : g_lane
		lane_ctl_t ctl;

		assign ctl.load_s2 = load_s2;
		assign ctl.update  = move_s3 && (USED_W'(i) < used);

		mdcd_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.diff_s1 (diff_s1),
			.drift   (drift_q[i]),
			.ctl     (ctl),
			.stat_q  (stats[i])
		);
	end

	// Sample count, saturating
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] count_next;
	logic [COUNT_W-1:0] count_s3;

	assign count_next = (&count_q) ? count_q : count_q + COUNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (move_s3) begin
			count_q <= count_next;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s3) begin
			count_s3 <= count_next;
		end
	end

	// Valid bits of the three stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (ready_s1) begin
				v_s1 <= s_axis_tvalid;
			end
			if (ready_s2) begin
				v_s2 <= v_s1;
			end
			if (ready_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// Stage 3: largest statistic and threshold compare
	stat_t best;
	logic  hit;

	mdcd_max #(
		.N (DRIFT_POINTS)
	) u_max (
		.stats (stats),
		.used  (used),
		.best  (best)
	);

	assign hit = best >= threshold_q;

	// Output register; words after the alarm are dropped
	logic alarmed_q;
	logic emit;

	assign emit = v_s3 && ready_out && !alarmed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
			alarmed_q     <= 1'b0;
		end else begin
			if (ready_out) begin
				m_axis_tvalid <= v_s3 && !alarmed_q;
			end
			if (emit && hit) begin
				alarmed_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_axis_tdata <= {count_s3, best};
			m_axis_tuser <= hit;
		end
	end

	// Assertions
	a_stop_after_alarm: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tuser |=> !m_axis_tvalid)
		else $error("result word produced after the alarm word");

	a_quiet_when_alarmed: assert property (@(posedge clk) disable iff (!arst_n)
		alarmed_q && !m_axis_tvalid |=> !m_axis_tvalid)
		else $error("output went valid while alarmed");

	a_index_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:STAT_W] != '0)
		else $error("result word with zero sample index");

endmodule

// ----- rtl/mdcd_lane.sv -----
`timescale 1ns / 1ps

module mdcd_lane (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic signed [mdcd_pkg::DIFF_W-1:0]   diff_s1,
	input  logic signed [mdcd_pkg::SAMPLE_W-1:0] drift,
	input  mdcd_pkg::lane_ctl_t                  ctl,
	output mdcd_pkg::stat_t                      stat_q
);
	import mdcd_pkg::*;

	logic signed [TDM_W-1:0]  tdm;
	logic signed [PROD_W-1:0] prod;
	logic signed [INC_W-1:0]  inc_s2;
	logic signed [SUM_W-1:0]  sum;
	stat_t                    stat_next;

	// Increment m * (2d - m) / 2, floored by the arithmetic shift
	assign tdm  = {diff_s1[DIFF_W-1], diff_s1, 1'b0}
		- {{(TDM_W-SAMPLE_W){drift[SAMPLE_W-1]}}, drift};
	assign prod = PROD_W'(tdm) * PROD_W'(drift);

	always_ff @(posedge clk) begin
		if (ctl.load_s2) begin
			inc_s2 <= prod[PROD_W-1:1];
		end
	end

	// Add and clamp to [0, all ones]
	assign sum = $signed({2'b00, stat_q}) + {{(SUM_W-INC_W){inc_s2[INC_W-1]}}, inc_s2};

	always_comb begin
		if (sum[SUM_W-1]) begin
			stat_next = '0;
		end else if (sum[STAT_W]) begin
			stat_next = '1;
		end else begin
			stat_next = sum[STAT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stat_q <= '0;
		end else if (ctl.update) begin
			stat_q <= stat_next;
		end
	end

endmodule

// ----- rtl/mdcd_max.sv -----
`timescale 1ns / 1ps

module mdcd_max #(
	parameter int unsigned N = 4
) (
	input  mdcd_pkg::stat_t                  stats [N],
	input  logic [mdcd_pkg::USED_W-1:0]      used,
	output mdcd_pkg::stat_t                  best
);
	import mdcd_pkg::*;

	// Largest statistic over the lanes in use; lanes out of use count as zero
	always_comb begin
		best = '0;
		for (int i = 0; i < N; i++) begin
			if (USED_W'(i) < used && stats[i] > best) begin
				best = stats[i];
			end
		end
	end

endmodule

// ----- dv/multi_drift_cusum_detector_core_tb.sv -----
`timescale 1ns / 1ps

module multi_drift_cusum_detector_core_tb;

	import mdcd_pkg::*;

	localparam int unsigned DRIFT_POINTS = 4;
	localparam longint     STAT_TOP      = 64'h0000_00FF_FFFF_FFFF;
	localparam logic [COUNT_W-1:0] COUNT_TOP = '1;
	localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN = 3'd7;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned HOLD_CYCLES   = 80;
	localparam int unsigned PHASE_WORDS   = 50;
	localparam int unsigned PHASES        = 7;
	localparam int unsigned CHUNK_WORDS   = 40;

	typedef enum logic [1:0] {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_t;
	typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;

	typedef struct packed {
		logic [STAT_W-1:0]  max_stat;
		logic [COUNT_W-1:0] index;
		logic               alarm;
	} cusum_result_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] value;
		logic                  typed;
		cusum_result_t         want;
	} dir_row_t;

	localparam int unsigned DIR_ROWS = 25;
	localparam cusum_result_t NO_WANT = '0;

	// Directed rows; only the two words straight after reset carry a typed result
	localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
		'{ROW_SAMPLE, 3'd0, 40'h0000, 1'b1, '{40'd0, 32'd1, 1'b0}},
		'{ROW_SAMPLE, 3'd0, 40'h0100, 1'b1, '{40'd32768, 32'd2, 1'b0}},
		'{ROW_SAMPLE, 3'd0, 40'h7FFF, 1'b0, NO_WANT},
		'{ROW_SAMPLE, 3'd0, 40'h8000, 1'b0, NO_WANT},
		'{ROW_SAMPLE, 3'd0, 40'hFFFF, 1'b0, NO_WANT},
		'{ROW_CFG, REG_DRIFTS_USED, 40'd1, 1'b0, NO_WANT},
		'{ROW_SAMPLE, 3'd0, 40'h0400, 1'b0, NO_WANT},
		// zero drift count behaves as one
		'{ROW_CFG, REG_DRIFTS_USED, 40'd0, 1'b0, NO_WANT},
		'{ROW_SAMPLE, 3'd0, 40'h0400, 1'b0, NO_WANT},
		// count above the grid size behaves as the full grid; held lanes rejoin
		'{ROW_CFG, REG_DRIFTS_USED, 40'd7, 1'b0, NO_WANT},
		'{ROW_SAMPLE, 3'd0, 40'hFC00, 1'b0, NO_WANT},
		'{ROW_CFG, REG_DRIFT_A, 40'h8000, 1'b0, NO_WANT},
		'{ROW_CFG, REG_DRIFT_B, 40'h7FFF, 1'b0, NO_WANT},
		'{ROW_CFG, REG_DRIFT_C, 40'h0000, 1'b0, NO_WANT},
		// odd drift: half-product rounds towards minus infinity
		'{ROW_CFG, REG_DRIFT_D, 40'hFFFF, 1'b0, NO_WANT},
		'{ROW_CFG, REG_BASELINE, 40'h8000, 1'b0, NO_WANT},
		'{ROW_SAMPLE, 3'd0, 40'h7FFF, 1'b0, NO_WANT},
		'{ROW_SAMPLE, 3'd0, 40'h8000, 1'b0, NO_WANT},
		'{ROW_CFG, REG_BASELINE, 40'h7FFF, 1'b0, NO_WANT},
		'{ROW_SAMPLE, 3'd0, 40'h8000, 1'b0, NO_WANT},
		// write to an index with no register behind it
		'{ROW_CFG, REG_UNKNOWN, 40'hFF_FFFF_FFFF, 1'b0, NO_WANT},
		'{ROW_CFG, REG_THRESHOLD, 40'hFF_FFFF_FFFE, 1'b0, NO_WANT},
		'{ROW_SAMPLE, 3'd0, 40'h7FFF, 1'b0, NO_WANT},
		// upper data bits beyond a 16-bit register are dropped
		'{ROW_CFG, REG_BASELINE, 40'hAB_CDEF_0000, 1'b0, NO_WANT},
		'{ROW_SAMPLE, 3'd0, 40'h0001, 1'b0, NO_WANT}
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [SAMPLE_W-1:0]   s_axis_tdata;    // [15:0] sample
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;    // [39:0] max_statistic, [71:40] sample_index
	logic                  m_axis_tuser;    // [0] alarm

	// Predictor copy of registers and detector state
	logic [SAMPLE_W-1:0] base_q;
	logic [STAT_W-1:0]   thresh_q;
	logic [USED_W-1:0]   used_q;
	logic [SAMPLE_W-1:0] drift_q [DRIFT_POINTS];
	logic [STAT_W-1:0]   stat_q [DRIFT_POINTS];
	logic [COUNT_W-1:0]  count_q;
	bit                  alarm_q;

	cusum_result_t due_reports [$];
	int unsigned   failures = 0;
	int unsigned   src_idle_pct = 0;
	int unsigned   snk_stall_pct = 0;
	int unsigned   hold_left = 0;
	bit            hold_request = 1'b0;
	idle_mode_t    idle_mode = IDLE_NONE;

	multi_drift_cusum_detector_core #(
		.DRIFT_POINTS(DRIFT_POINTS)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always #5 clk = ~clk;

	// Hard stop for a hung run
	initial begin
		#5_000_000;
		$display("[multi_drift_cusum_detector_core] ERROR");
		$finish;
	end

	function automatic int unsigned lanes_in_use();
		if (used_q == 0)
			return 1;
		if (used_q > DRIFT_POINTS)
			return DRIFT_POINTS;
		return int'(used_q);
	endfunction

	// One lane: Q + floor(m*(2d - m)/2), clamped to the statistic range
	function automatic logic [STAT_W-1:0] lane_next(input logic [STAT_W-1:0] stat,
			input logic [SAMPLE_W-1:0] drift, input logic [SAMPLE_W-1:0] smp);
		longint d, m, q;
		d = longint'($signed(smp)) - longint'($signed(base_q));
		m = longint'($signed(drift));
		q = longint'(stat) + ((m * (2 * d - m)) >>> 1);
		if (q < 0)
			q = 0;
		if (q > STAT_TOP)
			q = STAT_TOP;
		return q[STAT_W-1:0];
	endfunction

	function automatic bit would_alarm(input logic [SAMPLE_W-1:0] smp);
		logic [STAT_W-1:0] best;
		best = '0;
		for (int i = 0; i < lanes_in_use(); i++)
			if (lane_next(stat_q[i], drift_q[i], smp) > best)
				best = lane_next(stat_q[i], drift_q[i], smp);
		return best >= thresh_q;
	endfunction

	// Largest statistic over all lanes, used or not
	function automatic logic [STAT_W-1:0] peak_stat();
		logic [STAT_W-1:0] pk;
		pk = '0;
		for (int i = 0; i < DRIFT_POINTS; i++)
			if (stat_q[i] > pk)
				pk = stat_q[i];
		return pk;
	endfunction

	// Advance the predictor by one sample and queue the report it gives; after the alarm it does nothing
	task automatic cusum_predict(input logic [SAMPLE_W-1:0] smp, input logic typed,
			input cusum_result_t want);
		cusum_result_t rep;
		if (alarm_q)
			return;
		rep = '0;
		for (int i = 0; i < lanes_in_use(); i++) begin
			stat_q[i] = lane_next(stat_q[i], drift_q[i], smp);
			if (stat_q[i] > rep.max_stat)
				rep.max_stat = stat_q[i];
		end
		if (count_q != COUNT_TOP)
			count_q = count_q + COUNT_W'(1);
		if (rep.max_stat >= thresh_q)
			alarm_q = 1'b1;
		rep.index = count_q;
		rep.alarm = alarm_q;
		if (typed)
			rep = want;
		due_reports = {due_reports, rep};
	endtask

	task automatic set_idle(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
			IDLE_SRC:  begin src_idle_pct = 66; snk_stall_pct = 0;  end
			IDLE_SNK:  begin src_idle_pct = 0;  snk_stall_pct = 66; end
			default:   begin src_idle_pct = 38; snk_stall_pct = 38; end
		endcase
	endtask

	task automatic next_idle();
		idle_mode = idle_mode_t'(idle_mode + 1'b1);
		set_idle(idle_mode);
	endtask

	// Offer one sample word; valid stays high into the next call unless a gap follows
	task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= smp;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	// Stop sending, drain every report, then let the pipeline settle
	task automatic quiesce();
		s_axis_tvalid <= 1'b0;
		while (due_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_BASELINE:    base_q     = data[SAMPLE_W-1:0];
			REG_THRESHOLD:   thresh_q   = data[STAT_W-1:0];
			REG_DRIFTS_USED: used_q     = data[USED_W-1:0];
			REG_DRIFT_A:     drift_q[0] = data[SAMPLE_W-1:0];
			REG_DRIFT_B:     drift_q[1] = data[SAMPLE_W-1:0];
			REG_DRIFT_C:     drift_q[2] = data[SAMPLE_W-1:0];
			REG_DRIFT_D:     drift_q[3] = data[SAMPLE_W-1:0];
			default: ;
		endcase
	endtask

	// Random 16-bit register value, biased towards extremes, with junk above bit 15
	function automatic logic [CFG_DATA_W-1:0] rand_q88();
		logic [SAMPLE_W-1:0] v;
		case ($urandom_range(0, 5))
			0:       v = 16'h8000;
			1:       v = 16'h7FFF;
			2:       v = 16'($urandom_range(0, 1023)) - 16'd512;
			default: v = 16'($urandom);
		endcase
		return {24'($urandom), v};
	endfunction

	// One random phase: new settings while idle, then shaped sample traffic
	task automatic run_phase(input bit all_regs, input bit squeeze);
		logic [SAMPLE_W-1:0] smp, shift;
		longint              pk, th;
		int unsigned         seg_left, seg_mode;
		quiesce();
		if (all_regs || $urandom_range(0, 2) != 0)
			write_reg(REG_BASELINE, rand_q88());
		if (all_regs || $urandom_range(0, 2) != 0)
			write_reg(REG_DRIFTS_USED, {37'($urandom), 3'($urandom_range(0, 7))});
		for (int i = 0; i < DRIFT_POINTS; i++)
			if (all_regs || $urandom_range(0, 2) != 0)
				write_reg(CFG_IDX_W'(REG_DRIFT_A + i), rand_q88());
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_UNKNOWN, {8'($urandom), 32'($urandom)});
		// Threshold stays above every held statistic so a zero-offset word never alarms
		pk = longint'(peak_stat());
		case ($urandom_range(0, 3))
			0:       th = STAT_TOP;
			1:       th = pk + 1 + $urandom_range(0, 255);
			2:       th = pk + 1 + longint'($urandom);
			default: th = longint'({8'($urandom), 32'($urandom)});
		endcase
		if (th <= pk)
			th = pk + 1;
		if (th > STAT_TOP)
			th = STAT_TOP;
		write_reg(REG_THRESHOLD, th[CFG_DATA_W-1:0]);

		seg_left = 0;
		seg_mode = 0;
		shift    = '0;
		for (int k = 0; k < PHASE_WORDS; k++) begin
			if (k % CHUNK_WORDS == 0)
				next_idle();
			if (squeeze && k == 5) begin
				set_idle(IDLE_NONE);
				hold_request = 1'b1;
			end
			// Segments: quiet around the baseline, shifted by a drift, wide noise, extremes
			if (seg_left == 0) begin
				seg_mode = $urandom_range(0, 9);
				seg_left = $urandom_range(4, 30);
				shift    = drift_q[$urandom_range(0, DRIFT_POINTS - 1)];
			end
			seg_left--;
			case (seg_mode)
				0, 1, 2, 3: smp = base_q + 16'($urandom_range(0, 511)) - 16'd256;
				4, 5, 6:    smp = base_q + shift + 16'($urandom_range(0, 511)) - 16'd256;
				7, 8:       smp = 16'($urandom);
				default: begin
					case ($urandom_range(0, 3))
						0:       smp = 16'h8000;
						1:       smp = 16'h7FFF;
						2:       smp = 16'h0000;
						default: smp = 16'hFFFF;
					endcase
				end
			endcase
			if (would_alarm(smp))
				smp = base_q;
			cusum_predict(smp, 1'b0, NO_WANT);
			send_sample(smp);
		end
	endtask

	// Result side: compare each accepted word, then choose the next ready
	always @(posedge clk) begin : sink
		cusum_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (due_reports.size() == 0) begin
				$error("unexpected result word: max_statistic %0h sample_index %0d alarm %0b",
					m_axis_tdata[STAT_W-1:0], m_axis_tdata[OUT_DATA_W-1:STAT_W], m_axis_tuser);
				failures++;
			end else begin
				want = due_reports.pop_front();
				if (m_axis_tdata[STAT_W-1:0] !== want.max_stat) begin
					$error("max_statistic: expected %0h, got %0h", want.max_stat,
						m_axis_tdata[STAT_W-1:0]);
					failures++;
				end
				if (m_axis_tdata[OUT_DATA_W-1:STAT_W] !== want.index) begin
					$error("sample_index: expected %0d, got %0d", want.index,
						m_axis_tdata[OUT_DATA_W-1:STAT_W]);
					failures++;
				end
				if (m_axis_tuser !== want.alarm) begin
					$error("alarm: expected %0b, got %0b", want.alarm, m_axis_tuser);
					failures++;
				end
			end
		end
		if (hold_request) begin
			hold_left    = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// Stimulus
	initial begin : stim
		logic [SAMPLE_W-1:0] smp;
		bit                  in_cfg;
		int unsigned         steps;

		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		base_q        = '0;
		thresh_q      = STAT_TOP[STAT_W-1:0];
		used_q        = 3'd4;
		drift_q[0]    = 16'h0100;
		drift_q[1]    = 16'h0200;
		drift_q[2]    = 16'hFF00;
		drift_q[3]    = 16'hFE00;
		for (int i = 0; i < DRIFT_POINTS; i++)
			stat_q[i] = '0;
		count_q = '0;
		alarm_q = 1'b0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		in_cfg = 1'b0;
		for (int r = 0; r < DIR_ROWS; r++) begin
			if (DIR_TABLE[r].kind == ROW_CFG) begin
				if (!in_cfg)
					quiesce();
				in_cfg = 1'b1;
				write_reg(DIR_TABLE[r].idx, DIR_TABLE[r].value);
			end else begin
				in_cfg = 1'b0;
				smp = DIR_TABLE[r].value[SAMPLE_W-1:0];
				cusum_predict(smp, DIR_TABLE[r].typed, DIR_TABLE[r].want);
				send_sample(smp);
			end
		end

		// Random phases under varied settings
		for (int p = 0; p < PHASES; p++)
			run_phase(p == 0, p == 2);

		// Sustained large shift: climb lane A until the next word would saturate it
		quiesce();
		write_reg(REG_BASELINE, 40'h8000);
		write_reg(REG_DRIFTS_USED, 40'd4);
		write_reg(REG_DRIFT_A, 40'h7FFF);
		write_reg(REG_DRIFT_B, rand_q88());
		write_reg(REG_DRIFT_C, rand_q88());
		write_reg(REG_DRIFT_D, rand_q88());
		write_reg(REG_THRESHOLD, STAT_TOP[CFG_DATA_W-1:0]);
		steps = 0;
		smp = 16'h7FFF - 16'($urandom_range(0, 2047));
		while (!would_alarm(smp)) begin
			if (steps % CHUNK_WORDS == 0)
				next_idle();
			if (steps == 30) begin
				set_idle(IDLE_NONE);
				hold_request = 1'b1;
			end
			cusum_predict(smp, 1'b0, NO_WANT);
			send_sample(smp);
			steps++;
			smp = 16'h7FFF - 16'($urandom_range(0, 2047));
		end

		// Zero threshold: the saturating word raises the alarm at once
		quiesce();
		set_idle(IDLE_BOTH);
		write_reg(REG_THRESHOLD, 40'd0);
		cusum_predict(smp, 1'b0, NO_WANT);
		send_sample(smp);

		// Words after the alarm are taken but give nothing
		for (int k = 0; k < 8; k++) begin
			smp = 16'($urandom);
			cusum_predict(smp, 1'b0, NO_WANT);
			send_sample(smp);
		end
		s_axis_tvalid <= 1'b0;

		while (due_reports.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (failures == 0)
			$display("[multi_drift_cusum_detector_core] OK");
		else
			$display("[multi_drift_cusum_detector_core] ERROR");
		$finish;
	end

endmodule
